/* hdl/cbf_pkg.sv */
package cbf_pkg;

  localparam int COORD_W = 16;
  localparam int N_COORD = 8;
  localparam int IN_W    = N_COORD * COORD_W;
  localparam int OUT_W   = 2 * COORD_W;
  localparam int SEG_W   = 6;
  localparam int CFG_W   = 8;

  localparam int COORD_MAX = 32767;
  localparam int COORD_MIN = -32768;

  localparam logic [SEG_W-1:0] SEG_RESET = 6'd16;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [3:0]                op_t;

  // per-point micro-op sequence on the shared multiplier
  localparam op_t OP_UU      = 4'd0;   // u*u
  localparam op_t OP_VV      = 4'd1;   // v*v
  localparam op_t OP_B3      = 4'd2;   // uu*u
  localparam op_t OP_B0      = 4'd3;   // vv*v
  localparam op_t OP_B1      = 4'd4;   // 3*u*vv
  localparam op_t OP_B2      = 4'd5;   // 3*uu*v
  localparam op_t OP_X0      = 4'd6;   // x blend, four steps
  localparam op_t OP_X3      = 4'd9;
  localparam op_t OP_Y0      = 4'd10;  // y blend, four steps
  localparam op_t OP_Y3      = 4'd13;
  localparam op_t OP_CAP_END = 4'd14;  // last product capture
  localparam op_t OP_EMIT    = 4'd15;

endpackage

/* hdl/cbf_mul.sv */
module cbf_mul #(
  parameter int OW = 18
) (
  input  logic                   clk,
  input  logic signed [OW-1:0]   a,
  input  logic signed [OW-1:0]   b,
  output logic signed [2*OW-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

/* hdl/cbf_div.sv */
// serial restoring divide of 2^(QW-1) by divisor, one quotient bit per cycle
module cbf_div #(
  parameter int QW = 17
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cbf_pkg::SEG_W-1:0]  divisor,
  output logic                       done,
  output logic [QW-1:0]              quot,
  output logic [cbf_pkg::SEG_W-1:0]  rem
);

  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0]             cnt_r;
  logic                      run_r;
  logic                      done_r;
  logic [QW-1:0]             q_r;
  logic [cbf_pkg::SEG_W-1:0] rem_r;

  logic                      bit_in;
  logic [cbf_pkg::SEG_W:0]   sh;
  logic [cbf_pkg::SEG_W:0]   diff;
  logic                      ge;

  always_comb begin
    bit_in = (cnt_r == CW'(QW));
    sh     = {rem_r, bit_in};
    ge     = (sh >= {1'b0, divisor});
    diff   = sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(QW);
        run_r <= 1'b1;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= '0;
      rem_r <= '0;
    end else if (run_r) begin
      q_r   <= {q_r[QW-2:0], ge};
      rem_r <= ge ? diff[cbf_pkg::SEG_W-1:0] : sh[cbf_pkg::SEG_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

/* hdl/cubic_bezier_flattener.sv */
// channel  | dir | handshake          | payload (low bit up)
// in_      | in  | in_tvalid/tready   | tdata: p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y
// out_     | out | out_tvalid/tready  | tdata: out_x out_y; tlast: last_point
// cfg_     | in  | cfg_tvalid/tready  | tdata[5:0]: segments
//
// One curve gives segments+3 points. A bit-serial divide gives the u step,
// then each point takes 14 products through the single shared multiplier.
// in_tready is high only between curves. A stalled output holds the sequencer.
// Reset is synchronous active low; segments resets to 16.
module cubic_bezier_flattener #(
  parameter int MAX_SEGMENTS     = 61,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [cbf_pkg::IN_W-1:0]    in_tdata,   // p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [cbf_pkg::OUT_W-1:0]   out_tdata,  // out_x out_y
  output logic                        out_tlast,
  input  logic                        cfg_tvalid,
  output logic                        cfg_tready,
  input  logic [cbf_pkg::CFG_W-1:0]   cfg_tdata   // segments
);

  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int UW = F + 1;
  localparam int OW = (F + 2 > 17) ? F + 2 : 17;
  localparam int PW = 2 * OW;
  localparam int AW = F + 19;
  localparam int RW = AW - F + 1;
  localparam int SW = cbf_pkg::SEG_W;

  localparam logic [UW-1:0]        ONE    = {1'b1, {F{1'b0}}};
  localparam logic [PW-1:0]        HALF_P = PW'(1) << (F - 1);
  localparam logic signed [AW:0]   HALF_A = (AW + 1)'(1) << (F - 1);
  localparam logic signed [RW-1:0] R_MAX  = RW'(cbf_pkg::COORD_MAX);
  localparam logic signed [RW-1:0] R_MIN  = RW'(cbf_pkg::COORD_MIN);
  localparam logic [SW-1:0]        MAXSEG = SW'(MAX_SEGMENTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P0   = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PT   = 3'd3;
  localparam logic [2:0] S_P3   = 3'd4;

  logic [2:0]              state_r;
  logic [2:0]              state_nxt;
  logic [SW-1:0]           seg_cfg_r;
  logic [SW-1:0]           seg_r;
  cbf_pkg::coord_t         pts_r [cbf_pkg::N_COORD];
  logic [SW-1:0]           k_r;
  logic [UW-1:0]           u_r;
  logic [SW-1:0]           r_r;
  cbf_pkg::op_t            op_r;
  logic [UW-1:0]           uu_r;
  logic [UW-1:0]           vv_r;
  logic [UW-1:0]           b_r [4];
  logic signed [AW-1:0]    accx_r;
  logic signed [AW-1:0]    accy_r;
  logic                    out_tvalid_r;
  logic [cbf_pkg::OUT_W-1:0] out_tdata_r;
  logic                    out_tlast_r;

  logic [UW-1:0]           v;
  logic [SW-1:0]           seg_eff;
  logic signed [OW-1:0]    mul_a;
  logic signed [OW-1:0]    mul_b;
  logic signed [PW-1:0]    p_r;
  logic [PW-1:0]           pu;
  logic [PW-1:0]           p3;
  logic [PW-1:0]           r1;
  logic [PW-1:0]           r3;
  logic signed [AW-1:0]    p_a;
  cbf_pkg::op_t            rel;
  cbf_pkg::op_t            cap;
  cbf_pkg::op_t            crel;
  logic                    cap_en;
  logic                    accept;
  logic                    out_free;
  logic                    want_push;
  logic                    push;
  logic                    div_start;
  logic                    div_done;
  logic [UW-1:0]           div_q;
  logic [SW-1:0]           div_rem;
  logic [SW:0]             r_sum;
  logic [SW:0]             r_dif;
  logic                    r_wrap;
  cbf_pkg::coord_t         px;
  cbf_pkg::coord_t         py;

  function automatic cbf_pkg::coord_t round_sat(input logic signed [AW-1:0] s);
    logic signed [AW:0]   t;
    logic signed [RW-1:0] r;
    t = {s[AW-1], s} + HALF_A;
    r = signed'(t[AW:F]);
    if (r > R_MAX) begin
      r = R_MAX;
    end else if (r < R_MIN) begin
      r = R_MIN;
    end
    return cbf_pkg::COORD_W'(r);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_tready = 1'b1;
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign want_push  = (state_r == S_P0) || (state_r == S_P3) ||
                      ((state_r == S_PT) && (op_r == cbf_pkg::OP_EMIT));
  assign push       = want_push && out_free;
  assign div_start  = (state_r == S_P0) && push;
  assign v          = ONE - u_r;

  always_comb begin
    if (seg_cfg_r == '0) begin
      seg_eff = SW'(1);
    end else if (seg_cfg_r > MAXSEG) begin
      seg_eff = MAXSEG;
    end else begin
      seg_eff = seg_cfg_r;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    rel   = op_r - cbf_pkg::OP_X0;
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      cbf_pkg::OP_UU: begin
        mul_a = OW'(u_r);
        mul_b = OW'(u_r);
      end
      cbf_pkg::OP_VV: begin
        mul_a = OW'(v);
        mul_b = OW'(v);
      end
      cbf_pkg::OP_B3: begin
        mul_a = OW'(uu_r);
        mul_b = OW'(u_r);
      end
      cbf_pkg::OP_B0: begin
        mul_a = OW'(vv_r);
        mul_b = OW'(v);
      end
      cbf_pkg::OP_B1: begin
        mul_a = OW'(u_r);
        mul_b = OW'(vv_r);
      end
      cbf_pkg::OP_B2: begin
        mul_a = OW'(uu_r);
        mul_b = OW'(v);
      end
      default: begin
        if (op_r inside {[cbf_pkg::OP_X0:cbf_pkg::OP_Y3]}) begin
          mul_a = OW'(pts_r[{rel[1:0], rel[2]}]);
          mul_b = OW'(b_r[rel[1:0]]);
        end
      end
    endcase
  end

  cbf_mul #(
    .OW (OW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  cbf_div #(
    .QW (UW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (seg_r),
    .done    (div_done),
    .quot    (div_q),
    .rem     (div_rem)
  );

  // product post-processing
  always_comb begin
    cap    = op_r - 1'b1;
    crel   = cap - cbf_pkg::OP_X0;
    cap_en = (state_r == S_PT) && (op_r != cbf_pkg::OP_UU) && (op_r <= cbf_pkg::OP_CAP_END);
    pu     = p_r;
    p3     = pu + (pu << 1);
    r1     = (pu + HALF_P) >> F;
    r3     = (p3 + HALF_P) >> F;
    p_a    = AW'(p_r);
  end

  always_comb begin
    r_sum  = {1'b0, r_r} + {1'b0, div_rem};
    r_dif  = r_sum - {1'b0, seg_r};
    r_wrap = (r_sum >= {1'b0, seg_r});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_P0;
      S_P0:   if (push) state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_PT;
      S_PT:   if (push && (k_r == seg_r)) state_nxt = S_P3;
      S_P3:   if (push) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      seg_cfg_r <= cbf_pkg::SEG_RESET;
      k_r       <= '0;
      u_r       <= '0;
      op_r      <= cbf_pkg::OP_UU;
    end else begin
      state_r <= state_nxt;
      if (cfg_tvalid && cfg_tready) begin
        seg_cfg_r <= cfg_tdata[SW-1:0];
      end
      if (accept) begin
        k_r  <= '0;
        u_r  <= '0;
        op_r <= cbf_pkg::OP_UU;
      end else if (state_r == S_PT) begin
        if (op_r != cbf_pkg::OP_EMIT) begin
          op_r <= op_r + 1'b1;
        end else if (push) begin
          op_r <= cbf_pkg::OP_UU;
          k_r  <= k_r + 1'b1;
          u_r  <= r_wrap ? (u_r + div_q + 1'b1) : (u_r + div_q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < cbf_pkg::N_COORD; i++) begin
        pts_r[i] <= in_tdata[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W];
      end
      seg_r <= seg_eff;
      r_r   <= seg_eff >> 1;
    end else if ((state_r == S_PT) && (op_r == cbf_pkg::OP_EMIT) && push) begin
      r_r <= r_wrap ? r_dif[SW-1:0] : r_sum[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cap_en) begin
      case (cap)
        cbf_pkg::OP_UU: uu_r   <= r1[UW-1:0];
        cbf_pkg::OP_VV: vv_r   <= r1[UW-1:0];
        cbf_pkg::OP_B3: b_r[3] <= r1[UW-1:0];
        cbf_pkg::OP_B0: b_r[0] <= r1[UW-1:0];
        cbf_pkg::OP_B1: b_r[1] <= r3[UW-1:0];
        cbf_pkg::OP_B2: b_r[2] <= r3[UW-1:0];
        default: begin
          if (crel[2]) begin
            accy_r <= (cap == cbf_pkg::OP_Y0) ? p_a : accy_r + p_a;
          end else begin
            accx_r <= (cap == cbf_pkg::OP_X0) ? p_a : accx_r + p_a;
          end
        end
      endcase
    end
  end

  always_comb begin
    case (state_r)
      S_P0: begin
        px = pts_r[0];
        py = pts_r[1];
      end
      S_P3: begin
        px = pts_r[6];
        py = pts_r[7];
      end
      default: begin
        px = round_sat(accx_r);
        py = round_sat(accy_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (push) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_tdata_r <= {py, px};
      out_tlast_r <= (state_r == S_P3);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

/* hdl/cbf_checker.sv */
module cbf_assertions (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [cbf_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tlast,
  input logic                      cfg_tready
);

  // empty and ready right after reset
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready && cfg_tready))
    else $error("not idle after reset");

  // one curve at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after request");

  // between curves only the closing point can be pending
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tlast))
    else $error("ready while a curve point is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output changed");

endmodule

bind cubic_bezier_flattener cbf_assertions u_cbf_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_tready (cfg_tready)
);

/* verif/cbf_checker.sv */
`timescale 1ns / 100ps

module cbf_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [cbf_pkg::IN_W-1:0]  in_tdata,   // p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [cbf_pkg::OUT_W-1:0] out_tdata,  // out_x out_y
  input  logic                      out_tlast,
  input  logic                      cfg_tvalid,
  input  logic                      cfg_tready,
  input  logic [cbf_pkg::CFG_W-1:0] cfg_tdata,  // segments
  output int                        fail_count,
  output int                        points_pending,
  output int                        curves_seen,
  output int                        cfg_seen
);

  localparam int              SEG_LIMIT    = 61;
  localparam int              FRAC_BITS    = 16;
  localparam longint unsigned W_ONE        = 64'd1 << FRAC_BITS;
  localparam longint unsigned W_HALF       = W_ONE >> 1;
  localparam int              REPORT_LIMIT = 10;

  typedef struct packed {
    cbf_pkg::coord_t x;
    cbf_pkg::coord_t y;
    logic            last;
  } point_t;

  point_t                    expected_points[$];
  logic [cbf_pkg::SEG_W-1:0] segments;

  function automatic longint unsigned round_w(input longint unsigned p);
    return (p + W_HALF) >> FRAC_BITS;
  endfunction

  function automatic cbf_pkg::coord_t blend_coord(input cbf_pkg::coord_t a,
                                                  input cbf_pkg::coord_t b,
                                                  input cbf_pkg::coord_t c,
                                                  input cbf_pkg::coord_t d,
                                                  input longint unsigned w0,
                                                  input longint unsigned w1,
                                                  input longint unsigned w2,
                                                  input longint unsigned w3);
    longint acc;
    acc = longint'(a) * longint'(w0) + longint'(b) * longint'(w1)
        + longint'(c) * longint'(w2) + longint'(d) * longint'(w3);
    acc = (acc + longint'(W_HALF)) >>> FRAC_BITS;
    if (acc > cbf_pkg::COORD_MAX) acc = cbf_pkg::COORD_MAX;
    else if (acc < cbf_pkg::COORD_MIN) acc = cbf_pkg::COORD_MIN;
    return cbf_pkg::coord_t'(acc);
  endfunction

  task automatic flatten_curve(input logic [cbf_pkg::IN_W-1:0] curve);
    cbf_pkg::coord_t pt [cbf_pkg::N_COORD];
    longint unsigned seg, u, v, uu, vv, w0, w1, w2, w3;
    for (int i = 0; i < cbf_pkg::N_COORD; i++)
      pt[i] = curve[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W];
    seg = segments;
    if (seg == 0) seg = 1;
    else if (seg > SEG_LIMIT) seg = SEG_LIMIT;
    expected_points.push_back(point_t'{pt[0], pt[1], 1'b0});
    for (longint unsigned k = 0; k <= seg; k++) begin
      u  = ((k << FRAC_BITS) + seg / 2) / seg;
      v  = W_ONE - u;
      uu = round_w(u * u);
      vv = round_w(v * v);
      w0 = round_w(vv * v);
      w1 = round_w(3 * u * vv);
      w2 = round_w(3 * uu * v);
      w3 = round_w(uu * u);
      expected_points.push_back(point_t'{
        blend_coord(pt[0], pt[2], pt[4], pt[6], w0, w1, w2, w3),
        blend_coord(pt[1], pt[3], pt[5], pt[7], w0, w1, w2, w3),
        1'b0});
    end
    expected_points.push_back(point_t'{pt[6], pt[7], 1'b1});
  endtask

  always @(posedge clk) begin
    point_t got, want;
    if (!rst_n) begin
      segments = cbf_pkg::SEG_RESET;
      expected_points.delete();
      fail_count  = 0;
      curves_seen = 0;
      cfg_seen    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = point_t'{out_tdata[cbf_pkg::COORD_W-1:0],
                       out_tdata[cbf_pkg::OUT_W-1:cbf_pkg::COORD_W], out_tlast};
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%t: unexpected point x=%0d y=%0d last=%0b",
                     $realtime, got.x, got.y, got.last);
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%t: mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       $realtime, want.x, want.y, want.last, got.x, got.y, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        flatten_curve(in_tdata);
        curves_seen++;
      end
      if (cfg_tvalid && cfg_tready) begin
        segments = cfg_tdata[cbf_pkg::SEG_W-1:0];
        cfg_seen++;
      end
    end
    points_pending = expected_points.size();
  end

endmodule

/* verif/tb_cubic_bezier_flattener.sv */
`timescale 1ns / 100ps

module tb_cubic_bezier_flattener;

  localparam int STALL_LIMIT      = 5000;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 64;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [cbf_pkg::IN_W-1:0]  in_tdata;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [cbf_pkg::OUT_W-1:0] out_tdata;
  logic                      out_tlast;
  logic                      cfg_tvalid;
  logic                      cfg_tready;
  logic [cbf_pkg::CFG_W-1:0] cfg_tdata;

  int   fail_count;
  int   points_pending;
  int   curves_seen;
  int   cfg_seen;

  logic src_idle;
  logic sink_idle;
  logic sink_hold_req;

  cubic_bezier_flattener i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  cbf_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_tvalid     (cfg_tvalid),
    .cfg_tready     (cfg_tready),
    .cfg_tdata      (cfg_tdata),
    .fail_count     (fail_count),
    .points_pending (points_pending),
    .curves_seen    (curves_seen),
    .cfg_seen       (cfg_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [cbf_pkg::IN_W-1:0] pack_curve(input int x0, input int y0,
                                                          input int x1, input int y1,
                                                          input int x2, input int y2,
                                                          input int x3, input int y3);
    return {16'(y3), 16'(x3), 16'(y2), 16'(x2), 16'(y1), 16'(x1), 16'(y0), 16'(x0)};
  endfunction

  function automatic logic [cbf_pkg::IN_W-1:0] random_curve();
    logic [cbf_pkg::IN_W-1:0]    c;
    logic [cbf_pkg::COORD_W-1:0] base;
    int                          kind;
    kind = $urandom_range(0, 9);
    base = cbf_pkg::COORD_W'($urandom);
    for (int i = 0; i < cbf_pkg::N_COORD; i++) begin
      case (kind)
        6: begin
          case ($urandom_range(0, 3))
            0:       c[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W] = 16'h8000;
            1:       c[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W] = 16'h7fff;
            2:       c[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W] = 16'h0000;
            default: c[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W] = 16'hffff;
          endcase
        end
        7: c[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W] = 16'($urandom_range(0, 255)) - 16'd128;
        8: c[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W] = base;
        9: begin
          // x pinned near the top, y near the bottom: saturation
          if (i % 2 == 0)
            c[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W] = 16'(32767 - $urandom_range(0, 700));
          else
            c[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W] = 16'(-32768 + $urandom_range(0, 700));
        end
        default: c[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W] = cbf_pkg::COORD_W'($urandom);
      endcase
    end
    return c;
  endfunction

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (points_pending != 0) @(negedge clk);
  endtask

  task automatic send_curve(input logic [cbf_pkg::IN_W-1:0] curve);
    int gap;
    int seen;
    gap = src_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    seen      = curves_seen;
    in_tvalid = 1'b1;
    in_tdata  = curve;
    while (curves_seen == seen) @(negedge clk);
  endtask

  task automatic write_segments(input logic [cbf_pkg::SEG_W-1:0] seg);
    int seen;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    seen                          = cfg_seen;
    cfg_tdata                     = cbf_pkg::CFG_W'($urandom);
    cfg_tdata[cbf_pkg::SEG_W-1:0] = seg;
    cfg_tvalid                    = 1'b1;
    while (cfg_seen == seen) @(negedge clk);
    cfg_tvalid = 1'b0;
  endtask

  initial begin : sink
    int gap;
    bit held;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req && !held) begin
        held       = 1'b1;
        out_tready = 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        out_tready = 1'b1;
      end else begin
        gap = sink_idle ? pick_gap() : 0;
        if (gap > 0) begin
          out_tready = 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_tready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_tvalid && cfg_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int                        n_items;
    logic [cbf_pkg::SEG_W-1:0] seg;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_tvalid    = 1'b0;
    cfg_tdata     = '0;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    sink_hold_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset value of segments
    send_curve(pack_curve(0, 0, 0, 0, 0, 0, 0, 0));
    send_curve(pack_curve(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_curve(pack_curve(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_curve(pack_curve(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768));
    send_curve(pack_curve(32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767));
    send_curve(pack_curve(-1, 1, 1, -1, -1, 1, 1, -1));
    send_curve(pack_curve(0, 0, 1, 0, 0, 1, 1, 1));
    send_curve(pack_curve(-32768, -32768, 0, 0, 0, 0, 32767, 32767));

    // zero acts as one segment
    write_segments(6'd0);
    send_curve(pack_curve(-32768, 32767, 0, 0, 0, 0, 32767, -32768));
    send_curve(pack_curve(3, -3, 32767, -32768, -32768, 32767, -3, 3));

    // values above the maximum clamp to it
    write_segments(6'd63);
    send_curve(pack_curve(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
    write_segments(6'd62);
    send_curve(random_curve());
    write_segments(6'd61);
    send_curve(pack_curve(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767));

    write_segments(6'd1);
    send_curve(pack_curve(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_curve(pack_curve(1, -1, -1, 1, 1, -1, -1, 1));
    write_segments(6'd2);
    send_curve(pack_curve(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    write_segments(6'd3);
    send_curve(pack_curve(100, -100, -7, 7, 7, -7, -100, 100));

    for (int p = 0; p < 14; p++) begin
      seg     = (p == 5) ? cbf_pkg::SEG_W'($urandom_range(58, 63))
                         : cbf_pkg::SEG_W'($urandom_range(0, 12));
      n_items = (p == 5) ? 6 : 25;
      write_segments(seg);
      src_idle  = (p % 4 != 3);
      sink_idle = (p % 4 != 3);
      if (p == 2) sink_hold_req = 1'b1;
      for (int n = 0; n < n_items; n++) begin
        if (p == 8 && n == 12) wait_drained();
        send_curve(random_curve());
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && points_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/cbf_pkg.sv
hdl/cbf_mul.sv
hdl/cbf_div.sv
hdl/cubic_bezier_flattener.sv
hdl/cbf_checker.sv
verif/cbf_checker.sv
verif/tb_cubic_bezier_flattener.sv
